// ----- sv/xbr_pkg.sv -----
// Package: shared types and constants of the XMODEM block receiver.
package xbr_pkg;

    localparam int BLOCK_BYTES   = 128;
    localparam int INDEX_BITS    = $clog2(BLOCK_BYTES);
    localparam int ADDR_BITS_DEF = 24;
    localparam int MEM_ADDR_BITS = 24;
    localparam int BYTE_BITS     = 8;

    localparam logic [BYTE_BITS-1:0] HDR_SOH  = 8'h01;
    localparam logic [BYTE_BITS-1:0] HDR_EOT  = 8'h04;
    localparam logic [BYTE_BITS-1:0] CODE_ACK = 8'h06;

    typedef enum logic [2:0] {
        PH_HEADER   = 3'd0,
        PH_BLKNUM   = 3'd1,
        PH_BLKINV   = 3'd2,
        PH_DATA     = 3'd3,
        PH_CHECK    = 3'd4,
        PH_FINISHED = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_ACK   = 2'd1,
        KIND_DONE  = 2'd2,
        KIND_FAIL  = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t                    kind;
        logic [MEM_ADDR_BITS-1:0] mem_address;
        logic [BYTE_BITS-1:0]     value;
    } result_t;

endpackage

// ----- sv/xbr_channels.sv -----
// Interfaces: valid/ready channels for received bytes and for results.
interface xbr_rx_if
    import xbr_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [BYTE_BITS-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface xbr_res_if
    import xbr_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [1:0]               kind;
    logic [MEM_ADDR_BITS-1:0] mem_address;
    logic [BYTE_BITS-1:0]     value;

    modport source (output valid, output kind, output mem_address, output value, input ready);
    modport sink (input valid, input kind, input mem_address, input value, output ready);
endinterface

// ----- sv/xbr_skid.sv -----
// Result register with one skid entry; ready toward the core is registered.
module xbr_skid
    import xbr_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  result_t       push_data,
    output logic          push_ready,
    xbr_res_if.source     res
);

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_reg, main_next;
    result_t skid_reg, skid_next;
    logic    pop;

    assign pop        = main_valid_reg && res.ready;
    assign push_ready = !skid_valid_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            // drain the skid entry into the output register
            if (pop)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
            begin
                main_next       = push_data;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign res.valid       = main_valid_reg;
    assign res.kind        = main_reg.kind;
    assign res.mem_address = main_reg.mem_address;
    assign res.value       = main_reg.value;

endmodule

// ----- sv/xmodem_block_receiver_core.sv -----
// Top level: XMODEM 128-byte block receiver producing memory writes and status results.
//
//   channel | dir | payload                          | transfer when
//   --------+-----+----------------------------------+------------------------
//   rx      | in  | rx_byte                          | rx.valid && rx.ready
//   res     | out | kind, mem_address, value         | res.valid && res.ready
//
// One byte per cycle while rx.ready is high: the phase update and the result are
// formed combinationally from the phase, index and block base registers, and the
// result lands in the result register of the skid stage.
// Reset clears the phase to header wait, the index and the block base to zero.
// A stalled result fills the skid entry; rx.ready then drops until it drains.
module xmodem_block_receiver_core
    import xbr_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    xbr_rx_if.sink    rx,
    xbr_res_if.source res
);

    localparam int EXT_BITS = (ADDR_BITS > MEM_ADDR_BITS) ? ADDR_BITS : MEM_ADDR_BITS;

    phase_t                phase_reg, phase_next;
    logic [INDEX_BITS-1:0] byte_index_reg, byte_index_next;
    logic [ADDR_BITS-1:0]  write_address_reg, write_address_next;

    logic                  accept;
    logic                  res_push;
    logic                  push_ready;
    result_t               res_data;
    logic [ADDR_BITS-1:0]  out_addr;
    logic [EXT_BITS-1:0]   out_addr_ext;
    kind_t                 res_kind;
    logic [BYTE_BITS-1:0]  res_value;
    logic                  produce;

    assign rx.ready = push_ready;
    assign accept   = rx.valid && rx.ready;

    always_comb
    begin
        phase_next         = phase_reg;
        byte_index_next    = byte_index_reg;
        write_address_next = write_address_reg;
        produce            = 1'b0;
        res_kind           = KIND_WRITE;
        res_value          = rx.rx_byte;
        out_addr           = write_address_reg;
        case (phase_reg)
            PH_HEADER:
            begin
                produce = 1'b1;
                if (rx.rx_byte == HDR_SOH)
                begin
                    produce         = 1'b0;
                    phase_next      = PH_BLKNUM;
                    byte_index_next = '0;
                end
                else if (rx.rx_byte == HDR_EOT)
                begin
                    phase_next = PH_FINISHED;
                    res_kind   = KIND_DONE;
                    res_value  = HDR_EOT;
                end
                else
                begin
                    phase_next = PH_FINISHED;
                    res_kind   = KIND_FAIL;
                end
            end
            PH_BLKNUM:
            begin
                phase_next = PH_BLKINV;
            end
            PH_BLKINV:
            begin
                phase_next      = PH_DATA;
                byte_index_next = '0;
            end
            PH_DATA:
            begin
                produce  = 1'b1;
                res_kind = KIND_WRITE;
                out_addr = write_address_reg + ADDR_BITS'(byte_index_reg);
                // the index wraps to zero after the last data byte
                byte_index_next = byte_index_reg + 1'b1;
                if (byte_index_reg == INDEX_BITS'(BLOCK_BYTES - 1))
                begin
                    phase_next = PH_CHECK;
                end
            end
            PH_CHECK:
            begin
                produce            = 1'b1;
                res_kind           = KIND_ACK;
                res_value          = CODE_ACK;
                write_address_next = write_address_reg + ADDR_BITS'(BLOCK_BYTES);
                byte_index_next    = '0;
                phase_next         = PH_HEADER;
            end
            default:
            begin
                // finished, or an unused code: hold and drop every byte
            end
        endcase
    end

    assign out_addr_ext         = EXT_BITS'(out_addr);
    assign res_data.kind        = res_kind;
    assign res_data.mem_address = out_addr_ext[MEM_ADDR_BITS-1:0];
    assign res_data.value       = res_value;
    assign res_push             = accept && produce;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_HEADER;
            byte_index_reg    <= '0;
            write_address_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg         <= phase_next;
            byte_index_reg    <= byte_index_next;
            write_address_reg <= write_address_next;
        end
    end

    xbr_skid u_skid (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (res_push),
        .push_data  (res_data),
        .push_ready (push_ready),
        .res        (res)
    );

`ifndef SYNTHESIS
    a_index_only_in_data: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_DATA) |-> (byte_index_reg == '0))
        else $error("byte index nonzero outside data phase");

    a_silent_when_finished: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_FINISHED) |-> !res_push)
        else $error("result produced after transfer ended");

    a_base_block_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (write_address_reg[INDEX_BITS-1:0] == '0))
        else $error("block base address not block aligned");
`endif

endmodule
